// ----- src/pci_pkg.sv -----
// Shared widths, types, constants and helpers for the perceptual colour interpolator.
// Used by every module of the block; depends on nothing.
package pci_pkg;

	// Fixed-point format: FRAC_BITS fractional bits, ONE means 1.0.
	localparam int FRAC_BITS = 16;
	localparam int W = FRAC_BITS + 1;
	localparam int DW = FRAC_BITS + 2;
	localparam int PW = W + 1 + DW;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

	// Configuration register file.
	localparam int NUM_REGS = 6;
	localparam int IW = 3;
	localparam logic [IW-1:0] REG_START_RED = IW'(0);
	localparam logic [IW-1:0] REG_START_GREEN = IW'(1);
	localparam logic [IW-1:0] REG_START_BLUE = IW'(2);
	localparam logic [IW-1:0] REG_END_RED = IW'(3);
	localparam logic [IW-1:0] REG_END_GREEN = IW'(4);
	localparam logic [IW-1:0] REG_END_BLUE = IW'(5);

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	// Values derived from the endpoint colours, held steady between writes.
	typedef struct packed {
		logic [W-1:0]         c0;
		logic [W-1:0]         c1;
		logic [2:0][DW-1:0]   dx0;
		logic [2:0][DW-1:0]   dx1;
	} setup_t;

	// One item in flight between front and back: luma and signed chroma offsets.
	typedef struct packed {
		logic [W-1:0]         y;
		logic [2:0][DW-1:0]   d;
	} item_t;

	// Values above 1.0 count as 1.0.
	function automatic logic [W-1:0] clamp_unit(input logic [W-1:0] v);
		return (v > ONE) ? ONE : v;
	endfunction

endpackage

// ----- src/pci_setup.sv -----
// Configuration registers and the sequencer that derives endpoint luma, cube roots and offsets.
// Depends on pci_pkg.
module pci_setup
	import pci_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [IW-1:0] cfg_index,
	input  logic [W-1:0]  cfg_data,
	output logic          busy,
	output setup_t        setup
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_CU   = 3'd4;

	localparam int LW = FRAC_BITS + 10;
	localparam int CW = $clog2(LW);
	// Rounded-up reciprocal of 1000; its error times any LW-bit numerator stays below 2^RSH.
	localparam int RSH = LW + 10;
	localparam logic [LW:0] RECIP = (LW+1)'(((64'd1 << RSH) + 64'd999) / 64'd1000);

	logic [W-1:0]    cfg_q [NUM_REGS];
	logic [2:0]      st_q;
	logic            ep_q;
	logic [CW-1:0]   cnt_q;
	logic [LW-1:0]   num_q;
	logic [W-1:0]    rt_q;
	logic [2*W-1:0]  sq_q;
	logic [W-1:0]    y_q [2];
	logic [W-1:0]    c_q [2];

	logic [W-1:0]    col [3];
	logic [LW-1:0]   num;
	logic [2*LW:0]   prod;
	logic [W-1:0]    quo;
	logic [W-1:0]    tr;
	logic [3*W-1:0]  cube;
	logic [3*W-1:0]  lim;
	logic [W-1:0]    rt_n;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= (i < 3) ? '0 : ONE;
			end
		end else if (cfg_we && cfg_index < IW'(NUM_REGS)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Colour of the endpoint being worked on, and its luma numerator.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			col[j] = clamp_unit(ep_q ? cfg_q[3 + j] : cfg_q[j]);
		end
		num = LW'(col[0]) * LW'(299) + LW'(col[1]) * LW'(587) + LW'(col[2]) * LW'(114)
			+ LW'(500);
	end

	// Luma division by 1000 as one multiplication by the reciprocal.
	assign prod = (2*LW+1)'(num_q) * (2*LW+1)'(RECIP);
	assign quo = prod[RSH +: W];

	// One bit of the cube root per square step and cube-and-compare step: square, then cube and compare.
	assign tr = rt_q | (W'(1) << cnt_q);
	assign cube = (3*W)'(sq_q) * (3*W)'(tr);
	assign lim = (3*W)'({y_q[ep_q], {(2*FRAC_BITS){1'b0}}});
	assign rt_n = (cube <= lim) ? tr : rt_q;

	// Sequencer control; any write to a register in the list restarts it from the start colour.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			ep_q <= 1'b0;
			cnt_q <= '0;
		end else if (cfg_we && cfg_index < IW'(NUM_REGS)) begin
			st_q <= ST_LOAD;
			ep_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					st_q <= ST_IDLE;
				end
				ST_LOAD: begin
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= CW'(FRAC_BITS);
					st_q <= ST_SQ;
				end
				ST_SQ: begin
					st_q <= ST_CU;
				end
				ST_CU: begin
					if (cnt_q == '0) begin
						if (ep_q) begin
							st_q <= ST_IDLE;
						end else begin
							ep_q <= 1'b1;
							st_q <= ST_LOAD;
						end
					end else begin
						cnt_q <= cnt_q - CW'(1);
						st_q <= ST_SQ;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_LOAD: begin
				num_q <= num;
			end
			ST_DIV: begin
				y_q[ep_q] <= quo;
				rt_q <= '0;
			end
			ST_SQ: begin
				sq_q <= tr * tr;
			end
			ST_CU: begin
				rt_q <= rt_n;
				if (cnt_q == '0) begin
					c_q[ep_q] <= rt_n;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = (st_q != ST_IDLE);

	// Cube roots and chroma offsets of both endpoints.
	always_comb begin
		setup.c0 = c_q[0];
		setup.c1 = c_q[1];
		for (int j = 0; j < 3; j++) begin
			setup.dx0[j] = DW'(clamp_unit(cfg_q[j])) - DW'(y_q[0]);
			setup.dx1[j] = DW'(clamp_unit(cfg_q[3 + j])) - DW'(y_q[1]);
		end
	end

endmodule

// ----- src/pci_front.sv -----
// Front pipeline: accepts weights, blends cube-root luma and chroma offsets.
// Depends on pci_pkg; feeds the queue.
module pci_front
	import pci_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] blend_weight,
	input  logic         busy,
	input  logic         cfg_we,
	input  setup_t       setup,
	output logic         push,
	output item_t        push_item,
	input  logic         full
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv;

	logic [W-1:0]   r_s1, q_s1;
	logic [2*W-1:0] pc0_s2, pc1_s2;
	logic signed [PW-1:0] pd0_s2 [3];
	logic signed [PW-1:0] pd1_s2 [3];
	logic [W-1:0]   w_s3, w_s4, t_s4, y_s5;
	logic [2:0][DW-1:0] d_s3, d_s4, d_s5;

	logic [2*W:0]   ws;
	logic [PW:0]    ds [3];
	logic [2*W:0]   ts;
	logic [2*W:0]   yy;

	// The whole pipeline moves when its last item can enter the queue.
	assign adv = !v_s5 || !full;
	assign in_ready = adv && !busy && !cfg_we;
	assign push = v_s5 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Rounded sums, floor division by ONE.
	always_comb begin
		ws = {1'b0, pc0_s2} + {1'b0, pc1_s2} + (2*W+1)'(HALF);
		for (int i = 0; i < 3; i++) begin
			ds[i] = {pd0_s2[i][PW-1], pd0_s2[i]} + {pd1_s2[i][PW-1], pd1_s2[i]}
				+ (PW+1)'(HALF);
		end
		ts = (2*W+1)'(w_s3) * (2*W+1)'(w_s3) + (2*W+1)'(HALF);
		yy = (2*W+1)'(t_s4) * (2*W+1)'(w_s4) + (2*W+1)'(HALF);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: clamp the weight and form its complement.
			r_s1 <= clamp_unit(blend_weight);
			q_s1 <= ONE - clamp_unit(blend_weight);
			// Stage 2: weighted endpoint terms.
			pc0_s2 <= q_s1 * setup.c0;
			pc1_s2 <= r_s1 * setup.c1;
			for (int i = 0; i < 3; i++) begin
				pd0_s2[i] <= $signed({1'b0, q_s1}) * $signed(setup.dx0[i]);
				pd1_s2[i] <= $signed({1'b0, r_s1}) * $signed(setup.dx1[i]);
			end
			// Stage 3: cube-root luma and chroma offsets.
			w_s3 <= ws[FRAC_BITS +: W];
			for (int i = 0; i < 3; i++) begin
				d_s3[i] <= ds[i][FRAC_BITS +: DW];
			end
			// Stage 4: square.
			t_s4 <= ts[FRAC_BITS +: W];
			w_s4 <= w_s3;
			d_s4 <= d_s3;
			// Stage 5: cube, clamped to one.
			y_s5 <= clamp_unit(yy[FRAC_BITS +: W]);
			d_s5 <= d_s4;
		end
	end

	assign push_item.y = y_s5;
	assign push_item.d = d_s5;

endmodule

// ----- src/pci_fifo.sv -----
// Short queue of items between the front and back pipelines.
// Depends on pci_pkg.
module pci_fifo
	import pci_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head
);

	item_t           mem_q [QDEPTH];
	logic [QAW-1:0]  wp_q, rp_q;
	logic [QAW:0]    cnt_q;
	logic            do_push, do_pop;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign head = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + QAW'(1);
			end
			cnt_q <= cnt_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_item;
		end
	end

endmodule

// ----- src/pci_back.sv -----
// Back pipeline: chroma scale factor by pipelined division, then final channels.
// Depends on pci_pkg; reads from the queue and drives the output register.
module pci_back
	import pci_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  item_t        head,
	input  logic         q_valid,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_red,
	output logic [W-1:0] out_green,
	output logic [W-1:0] out_blue
);

	localparam int ND = FRAC_BITS;

	logic adv;

	logic                      dv_v_s   [0:ND];
	logic [W-1:0]              dv_y_s   [0:ND];
	logic [2:0][DW-1:0]        dv_d_s   [0:ND];
	logic [2:0][W-1:0]         dv_mag_s [0:ND];
	logic [2:0][W-1:0]         dv_rem_s [0:ND];
	logic [2:0][FRAC_BITS-1:0] dv_quo_s [0:ND];
	logic [2:0]                dv_sat_s [0:ND];

	logic v_s1, v_s2, v_s3;
	logic [W-1:0]         hmin_s1, y_s1, y_s2;
	logic [2:0][DW-1:0]   d_s1;
	logic signed [PW-1:0] prod_s2 [3];
	logic [W-1:0]         out_s3 [3];

	logic signed [DW-1:0] ld_d [3];
	logic [W-1:0]         ld_mag [3];
	logic [W-1:0]         ld_room [3];
	logic [W-1:0]         hc [3];
	logic [W-1:0]         hm;
	logic signed [DW:0]   vs [3];

	assign adv = !v_s3 || out_ready;
	assign pop = adv && q_valid;

	// Magnitude and headroom of each offset; a zero offset or ample room gives factor one.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ld_d[i] = $signed(head.d[i]);
			ld_mag[i] = ld_d[i][DW-1] ? W'(-ld_d[i]) : W'(ld_d[i]);
			ld_room[i] = ld_d[i][DW-1] ? head.y : ONE - head.y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_y_s[0] <= head.y;
			dv_d_s[0] <= head.d;
			for (int i = 0; i < 3; i++) begin
				dv_mag_s[0][i] <= ld_mag[i];
				dv_rem_s[0][i] <= ld_room[i];
				dv_quo_s[0][i] <= '0;
				dv_sat_s[0][i] <= (ld_d[i] == '0) || (ld_room[i] >= ld_mag[i]);
			end
		end
	end

	// Restoring division room * ONE / magnitude, one quotient bit per stage.
	for (genvar k = 1; k <= ND; k++) begin : g_div
		for (genvar i = 0; i < 3; i++) begin : g_ch
			logic [W-1:0] rs;
			logic         ge;
			assign rs = {dv_rem_s[k-1][i][W-2:0], 1'b0};
			assign ge = (rs >= dv_mag_s[k-1][i]);
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[k][i] <= ge ? rs - dv_mag_s[k-1][i] : rs;
					dv_quo_s[k][i] <= {dv_quo_s[k-1][i][FRAC_BITS-2:0], ge};
					dv_mag_s[k][i] <= dv_mag_s[k-1][i];
					dv_sat_s[k][i] <= dv_sat_s[k-1][i];
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_y_s[k] <= dv_y_s[k-1];
				dv_d_s[k] <= dv_d_s[k-1];
			end
		end
	end

	// Common factor is the smallest of the per-channel limits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hc[i] = dv_sat_s[ND][i] ? ONE : {1'b0, dv_quo_s[ND][i]};
		end
		hm = hc[0];
		if (hc[1] < hm) begin
			hm = hc[1];
		end
		if (hc[2] < hm) begin
			hm = hc[2];
		end
	end

	// Luma plus scaled offset, saturated to the unit range.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vs[i] = $signed({2'b00, y_s2}) + $signed({prod_s2[i][FRAC_BITS + DW - 1],
				prod_s2[i][FRAC_BITS +: DW]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= dv_v_s[ND];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hmin_s1 <= hm;
			y_s1 <= dv_y_s[ND];
			d_s1 <= dv_d_s[ND];
			y_s2 <= y_s1;
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= $signed({1'b0, hmin_s1}) * $signed(d_s1[i]);
				if (vs[i] < 0) begin
					out_s3[i] <= '0;
				end else if (vs[i] > $signed({2'b00, ONE})) begin
					out_s3[i] <= ONE;
				end else begin
					out_s3[i] <= vs[i][W-1:0];
				end
			end
		end
	end

	assign out_valid = v_s3;
	assign out_red = out_s3[0];
	assign out_green = out_s3[1];
	assign out_blue = out_s3[2];

endmodule

// ----- src/perceptual_color_interpolator_core.sv -----
// Top level of the perceptual colour interpolator.
// Depends on pci_pkg, pci_setup, pci_front, pci_fifo and pci_back.

// Takes one blend weight per clock while in_ready is high and returns one RGB colour per
// weight, in order, through five front stages, the queue, a division stage per fractional
// bit and four more back stages. After reset and after every register write a setup
// sequencer derives the endpoint luma (a load state and one reciprocal multiplication for
// the division by 1000) and cube roots (a square step and a cube-and-compare step per root
// bit) for both endpoints, during which in_ready is low. A write in the same cycle as a
// weight also holds in_ready low.
module perceptual_color_interpolator_core
	import pci_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [IW-1:0] cfg_index,
	input  logic [W-1:0]  cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [W-1:0]  blend_weight,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [W-1:0]  out_red,
	output logic [W-1:0]  out_green,
	output logic [W-1:0]  out_blue
);

	logic   busy;
	setup_t setup;
	logic   push, full, pop, not_empty;
	item_t  push_item, head;

	pci_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.setup     (setup)
	);

	pci_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.blend_weight (blend_weight),
		.busy         (busy),
		.cfg_we       (cfg_we),
		.setup        (setup),
		.push         (push),
		.push_item    (push_item),
		.full         (full)
	);

	pci_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	pci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_valid   (not_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue)
	);

endmodule

// ----- src/pci_checker.sv -----
// Port-level checks for the perceptual colour interpolator, bound to the top level.
// Depends on pci_pkg and perceptual_color_interpolator_core.
module pci_checker
	import pci_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	input logic          cfg_we,
	input logic [IW-1:0] cfg_index,
	input logic [W-1:0]  cfg_data,
	input logic          in_valid,
	input logic          in_ready,
	input logic [W-1:0]  blend_weight,
	input logic          out_valid,
	input logic          out_ready,
	input logic [W-1:0]  out_red,
	input logic [W-1:0]  out_green,
	input logic [W-1:0]  out_blue
);

	logic [7:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Items taken in and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue))
		else $error("stalled result changed");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_red <= ONE && out_green <= ONE && out_blue <= ONE)
		else $error("result channel above one");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_ready)
		else $error("item taken during a register write");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != '0)
		else $error("result with no item outstanding");

endmodule

bind perceptual_color_interpolator_core pci_checker u_chk (.*);
